// ===== rtl/temporal_information_stddev_max_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the temporal information block
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef TEMPORAL_INFORMATION_STDDEV_MAX_DEFINES_SVH
`define TEMPORAL_INFORMATION_STDDEV_MAX_DEFINES_SVH

`ifndef ASSERT_OFF

// The antecedent implies the consequent in the same cycle.
`define TISM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define TISM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TISM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define TISM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/tism_pkg.sv =====
// ----------------------------------------------------------------------------
// tism_pkg
// Types, constants and width helpers shared by the temporal information block.
// ----------------------------------------------------------------------------
package tism_pkg;

    localparam int CFG_W     = 12;
    localparam int CFG_MAX   = 4095;
    localparam int CFG_IDX_W = 1;
    localparam int TI_W      = 16;
    localparam int FRAC_W    = 16;
    localparam int X_W       = 32;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd1920;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd1080;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    // Datapath phase codes.
    localparam logic [2:0] PH_NQ   = 3'd0;
    localparam logic [2:0] PH_SS   = 3'd1;
    localparam logic [2:0] PH_DEN  = 3'd2;
    localparam logic [2:0] PH_DIV  = 3'd3;
    localparam logic [2:0] PH_SQRT = 3'd4;

    typedef struct packed {
        logic signed [8:0] map_value;
        logic              first_of_sequence;
    } pixel_t;

    typedef struct packed {
        logic [TI_W-1:0] frame_ti;
        logic [TI_W-1:0] max_ti;
    } result_t;

    typedef struct packed {
        logic       capture;
        logic       load;
        logic       step;
        logic       finish;
        logic [2:0] phase;
    } tism_cmd_t;

    // A 12-bit size register can never exceed CFG_MAX.
    function automatic int tism_eff(input int m);
        return (m < CFG_MAX) ? m : CFG_MAX;
    endfunction

    function automatic longint tism_n_max(input int mw, input int mh);
        return longint'(tism_eff(mw)) * longint'(tism_eff(mh));
    endfunction

    // Bits to hold the pixel count itself.
    function automatic int tism_n_w(input int mw, input int mh);
        return $clog2(tism_n_max(mw, mh) + 64'd1);
    endfunction

    // Bits for a pixel index within a frame.
    function automatic int tism_cnt_w(input int mw, input int mh);
        return $clog2(tism_n_max(mw, mh));
    endfunction

    // Bits for the magnitude of the frame's value sum.
    function automatic int tism_mag_w(input int mw, input int mh);
        return $clog2(tism_n_max(mw, mh) * 64'd256 + 64'd1);
    endfunction

    // Bits for the frame's sum of squares.
    function automatic int tism_q_w(input int mw, input int mh);
        return $clog2(tism_n_max(mw, mh) * 64'd65536 + 64'd1);
    endfunction

endpackage

// ===== rtl/tism_accum.sv =====
// ----------------------------------------------------------------------------
// tism_accum
// Per-frame accumulation of map values, their squares and the pixel index.
// ----------------------------------------------------------------------------
module tism_accum #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   accept,
    input  tism_pkg::pixel_t                                       pixel,
    input  logic [tism_pkg::CFG_W-1:0]                             frame_width,
    input  logic [tism_pkg::CFG_W-1:0]                             frame_height,
    output logic                                                   frame_end,
    output logic [tism_pkg::tism_n_w(MAX_WIDTH, MAX_HEIGHT)-1:0]   pixel_count,
    output logic [tism_pkg::tism_mag_w(MAX_WIDTH, MAX_HEIGHT)-1:0] sum_mag,
    output logic [tism_pkg::tism_q_w(MAX_WIDTH, MAX_HEIGHT)-1:0]   square_total
);
    import tism_pkg::*;

    localparam int N_W   = tism_n_w(MAX_WIDTH, MAX_HEIGHT);
    localparam int CNT_W = tism_cnt_w(MAX_WIDTH, MAX_HEIGHT);
    localparam int MAG_W = tism_mag_w(MAX_WIDTH, MAX_HEIGHT);
    localparam int SUM_W = MAG_W + 1;
    localparam int Q_W   = tism_q_w(MAX_WIDTH, MAX_HEIGHT);
    localparam int W_EFF = tism_eff(MAX_WIDTH);
    localparam int H_EFF = tism_eff(MAX_HEIGHT);

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [Q_W-1:0]          sq_reg, sq_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    logic [CFG_W-1:0]        width_cl;
    logic [CFG_W-1:0]        height_cl;
    logic signed [SUM_W-1:0] sum_base;
    logic signed [SUM_W-1:0] sum_new;
    logic [Q_W-1:0]          sq_base;
    logic [Q_W-1:0]          sq_new;
    logic [CNT_W-1:0]        cnt_base;
    logic [N_W-1:0]          cnt_inc;
    logic [8:0]              value_mag;
    logic [17:0]             value_sq;

    // Clamp the frame size so that a frame always holds at least two pixels.
    always_comb
    begin
        if (frame_width < CFG_W'(2))
            width_cl = CFG_W'(2);
        else if (int'(frame_width) > W_EFF)
            width_cl = CFG_W'(W_EFF);
        else
            width_cl = frame_width;

        if (frame_height < CFG_W'(1))
            height_cl = CFG_W'(1);
        else if (int'(frame_height) > H_EFF)
            height_cl = CFG_W'(H_EFF);
        else
            height_cl = frame_height;
    end

    assign pixel_count = N_W'({{CFG_W{1'b0}}, width_cl} * {{CFG_W{1'b0}}, height_cl});

    // A new clip restarts the frame, so this pixel is its first.
    assign sum_base = pixel.first_of_sequence ? '0 : sum_reg;
    assign sq_base  = pixel.first_of_sequence ? '0 : sq_reg;
    assign cnt_base = pixel.first_of_sequence ? '0 : cnt_reg;

    // Two's complement magnitude; the value -256 yields 256 in nine bits.
    assign value_mag = pixel.map_value[8] ? (~pixel.map_value + 9'd1) : pixel.map_value;
    assign value_sq  = {9'd0, value_mag} * {9'd0, value_mag};

    assign sum_new = sum_base + SUM_W'(pixel.map_value);
    assign sq_new  = sq_base + Q_W'(value_sq);
    assign cnt_inc = N_W'(cnt_base) + N_W'(1);

    // The frame ends once the index reaches the current count minus one.
    assign frame_end = (cnt_inc >= pixel_count);

    assign sum_mag      = sum_new[SUM_W-1] ? MAG_W'(-sum_new) : MAG_W'(sum_new);
    assign square_total = sq_new;

    always_comb
    begin
        sum_next = sum_reg;
        sq_next  = sq_reg;
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                sum_next = '0;
                sq_next  = '0;
                cnt_next = '0;
            end
            else
            begin
                sum_next = sum_new;
                sq_next  = sq_new;
                cnt_next = CNT_W'(cnt_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            sq_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            sq_reg  <= sq_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/tism_dp.sv =====
// ----------------------------------------------------------------------------
// tism_dp
// Shift-add multiplier, restoring divider and integer square root that turn
// one frame's sums into its standard deviation, plus the running maximum and
// the output register that holds a finished result until its transfer.
// ----------------------------------------------------------------------------
module tism_dp #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  tism_pkg::tism_cmd_t                                    cmd,
    input  logic                                                   clear_max,
    input  logic [tism_pkg::tism_n_w(MAX_WIDTH, MAX_HEIGHT)-1:0]   pixel_count,
    input  logic [tism_pkg::tism_mag_w(MAX_WIDTH, MAX_HEIGHT)-1:0] sum_mag,
    input  logic [tism_pkg::tism_q_w(MAX_WIDTH, MAX_HEIGHT)-1:0]   square_total,
    output tism_pkg::result_t                                      result
);
    import tism_pkg::*;

    localparam int N_W   = tism_n_w(MAX_WIDTH, MAX_HEIGHT);
    localparam int MAG_W = tism_mag_w(MAX_WIDTH, MAX_HEIGHT);
    localparam int Q_W   = tism_q_w(MAX_WIDTH, MAX_HEIGHT);
    localparam int NUM_W = N_W + Q_W;
    localparam int DEN_W = 2 * N_W;
    localparam int DVD_W = NUM_W + FRAC_W;
    localparam int ROOT_W = X_W / 2;

    logic [N_W-1:0]    n_reg, n_next;
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic [Q_W-1:0]    q_reg, q_next;
    logic [NUM_W-1:0]  acc_reg, acc_next;
    logic [NUM_W-1:0]  mcand_reg, mcand_next;
    logic [MAG_W-1:0]  mplr_reg, mplr_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [X_W-1:0]    quo_reg, quo_next;
    logic              ovf_reg, ovf_next;
    logic [X_W-1:0]    x_reg, x_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [ROOT_W+1:0] srem_reg, srem_next;
    logic [TI_W-1:0]   ti_reg, ti_next;
    logic [TI_W-1:0]   out_max_reg, out_max_next;
    logic [TI_W-1:0]   max_reg, max_next;
    logic              have_reg, have_next;

    always_comb
    begin
        logic [DEN_W:0]    div_trial;
        logic [ROOT_W+3:0] sq_shift;
        logic [ROOT_W+3:0] sq_trial;
        logic [TI_W-1:0]   ti_val;

        n_next       = n_reg;
        mag_next     = mag_reg;
        q_next       = q_reg;
        acc_next     = acc_reg;
        mcand_next   = mcand_reg;
        mplr_next    = mplr_reg;
        den_next     = den_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        ovf_next     = ovf_reg;
        x_next       = x_reg;
        root_next    = root_reg;
        srem_next    = srem_reg;
        ti_next      = ti_reg;
        out_max_next = out_max_reg;
        max_next     = max_reg;
        have_next    = have_reg;

        div_trial = {rem_reg, dvd_reg[DVD_W-1]};
        sq_shift  = {srem_reg, x_reg[X_W-1:X_W-2]};
        sq_trial  = {2'b00, root_reg, 2'b01};
        ti_val    = ovf_reg ? {TI_W{1'b1}} : root_reg;

        if (cmd.capture)
        begin
            n_next   = pixel_count;
            mag_next = sum_mag;
            q_next   = square_total;
        end

        if (cmd.load)
        begin
            case (cmd.phase)
                PH_NQ:
                begin
                    acc_next   = '0;
                    mcand_next = NUM_W'(q_reg);
                    mplr_next  = MAG_W'(n_reg);
                end
                PH_SS:
                begin
                    mcand_next = NUM_W'(mag_reg);
                    mplr_next  = mag_reg;
                end
                PH_DEN:
                begin
                    den_next   = '0;
                    mcand_next = NUM_W'(n_reg);
                    mplr_next  = MAG_W'(n_reg - N_W'(1));
                end
                PH_DIV:
                begin
                    dvd_next = {acc_reg, {FRAC_W{1'b0}}};
                    rem_next = '0;
                    quo_next = '0;
                    ovf_next = 1'b0;
                end
                PH_SQRT:
                begin
                    x_next    = quo_reg;
                    root_next = '0;
                    srem_next = '0;
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end

        if (cmd.step)
        begin
            case (cmd.phase)
                PH_NQ:
                begin
                    if (mplr_reg[0])
                        acc_next = acc_reg + mcand_reg;
                    mcand_next = {mcand_reg[NUM_W-2:0], 1'b0};
                    mplr_next  = mplr_reg >> 1;
                end
                PH_SS:
                begin
                    // A frame cut short by a smaller size can make the difference
                    // wrap; the quotient is then far beyond range and saturates.
                    if (mplr_reg[0])
                        acc_next = acc_reg - mcand_reg;
                    mcand_next = {mcand_reg[NUM_W-2:0], 1'b0};
                    mplr_next  = mplr_reg >> 1;
                end
                PH_DEN:
                begin
                    if (mplr_reg[0])
                        den_next = den_reg + DEN_W'(mcand_reg);
                    mcand_next = {mcand_reg[NUM_W-2:0], 1'b0};
                    mplr_next  = mplr_reg >> 1;
                end
                PH_DIV:
                begin
                    // Any quotient bit pushed past the kept 32 means TI saturates.
                    ovf_next = ovf_reg | quo_reg[X_W-1];
                    dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
                    if (div_trial >= {1'b0, den_reg})
                    begin
                        rem_next = DEN_W'(div_trial - {1'b0, den_reg});
                        quo_next = {quo_reg[X_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = div_trial[DEN_W-1:0];
                        quo_next = {quo_reg[X_W-2:0], 1'b0};
                    end
                end
                PH_SQRT:
                begin
                    x_next = {x_reg[X_W-3:0], 2'b00};
                    if (sq_shift >= sq_trial)
                    begin
                        srem_next = (ROOT_W+2)'(sq_shift - sq_trial);
                        root_next = {root_reg[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        srem_next = (ROOT_W+2)'(sq_shift);
                        root_next = {root_reg[ROOT_W-2:0], 1'b0};
                    end
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end

        // The output register keeps its own copy of the maximum, so a new clip
        // may clear the running maximum while a result still waits.
        if (cmd.finish)
        begin
            ti_next = ti_val;
            if (!have_reg || (ti_val > max_reg))
            begin
                max_next     = ti_val;
                out_max_next = ti_val;
            end
            else
            begin
                out_max_next = max_reg;
            end
            have_next = 1'b1;
        end

        if (clear_max)
        begin
            max_next  = '0;
            have_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        mag_reg     <= mag_next;
        q_reg       <= q_next;
        acc_reg     <= acc_next;
        mcand_reg   <= mcand_next;
        mplr_reg    <= mplr_next;
        den_reg     <= den_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        ovf_reg     <= ovf_next;
        x_reg       <= x_next;
        root_reg    <= root_next;
        srem_reg    <= srem_next;
        ti_reg      <= ti_next;
        out_max_reg <= out_max_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg  <= '0;
            have_reg <= 1'b0;
        end
        else
        begin
            max_reg  <= max_next;
            have_reg <= have_next;
        end
    end

    assign result.frame_ti = ti_reg;
    assign result.max_ti   = out_max_reg;

endmodule

// ===== rtl/tism_ctrl.sv =====
// ----------------------------------------------------------------------------
// tism_ctrl
// Sequencer for the per-frame arithmetic: walks the datapath through its
// multiply, divide and square root phases and tracks the output register.
// ----------------------------------------------------------------------------
module tism_ctrl #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                frame_start,
    input  logic                result_taken,
    output tism_pkg::tism_cmd_t cmd,
    output logic                busy,
    output logic                result_valid
);
    import tism_pkg::*;

    localparam int N_W    = tism_n_w(MAX_WIDTH, MAX_HEIGHT);
    localparam int MAG_W  = tism_mag_w(MAX_WIDTH, MAX_HEIGHT);
    localparam int Q_W    = tism_q_w(MAX_WIDTH, MAX_HEIGHT);
    localparam int DIV_N  = N_W + Q_W + FRAC_W;
    localparam int SQRT_N = X_W / 2;
    localparam int STEP_W = $clog2(DIV_N + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_NQ   = 3'd1;
    localparam logic [2:0] ST_SS   = 3'd2;
    localparam logic [2:0] ST_DEN  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_SQRT = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [STEP_W-1:0] phase_len;
    logic [2:0]        phase_after;

    always_comb
    begin
        case (state_reg)
            ST_NQ:
            begin
                phase_len   = STEP_W'(N_W);
                phase_after = ST_SS;
            end
            ST_SS:
            begin
                phase_len   = STEP_W'(MAG_W);
                phase_after = ST_DEN;
            end
            ST_DEN:
            begin
                phase_len   = STEP_W'(N_W);
                phase_after = ST_DIV;
            end
            ST_DIV:
            begin
                phase_len   = STEP_W'(DIV_N);
                phase_after = ST_SQRT;
            end
            ST_SQRT:
            begin
                phase_len   = STEP_W'(SQRT_N);
                phase_after = ST_FIN;
            end
            default:
            begin
                phase_len   = '0;
                phase_after = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !result_taken;
        cmd.capture    = 1'b0;
        cmd.load       = 1'b0;
        cmd.step       = 1'b0;
        cmd.finish     = 1'b0;
        cmd.phase      = PH_NQ;

        case (state_reg)
            ST_NQ:   cmd.phase = PH_NQ;
            ST_SS:   cmd.phase = PH_SS;
            ST_DEN:  cmd.phase = PH_DEN;
            ST_DIV:  cmd.phase = PH_DIV;
            ST_SQRT: cmd.phase = PH_SQRT;
            default: cmd.phase = PH_NQ;
        endcase

        case (state_reg)
            ST_IDLE:
            begin
                if (frame_start)
                begin
                    cmd.capture = 1'b1;
                    cnt_next    = '0;
                    state_next  = ST_NQ;
                end
            end
            ST_NQ, ST_SS, ST_DEN, ST_DIV, ST_SQRT:
            begin
                // The first cycle of a phase loads its operands, the rest iterate.
                if (cnt_reg == '0)
                    cmd.load = 1'b1;
                else
                    cmd.step = 1'b1;

                if (cnt_reg == phase_len)
                begin
                    cnt_next   = '0;
                    state_next = phase_after;
                end
                else
                begin
                    cnt_next = cnt_reg + STEP_W'(1);
                end
            end
            ST_FIN:
            begin
                // The output register must be empty or emptied by this cycle's transfer.
                if (!out_valid_reg || result_taken)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;

endmodule

// ===== rtl/temporal_information_stddev_max.sv =====
// ----------------------------------------------------------------------------
// temporal_information_stddev_max
// Temporal information: per-frame standard deviation of a temporal map and
// its running maximum over a clip, both in unsigned 8.8 fixed point.
// ----------------------------------------------------------------------------
// Map pixels are taken one per clock. The last pixel of a frame starts the
// per-frame arithmetic, which runs in the background while the next frame's
// pixels keep flowing; it is one shared shift-add multiplier, a restoring
// divider and a square root unit, each retiring one bit per cycle. Each phase
// first loads its operands and then iterates, and a finishing step writes
// the output register. The finished result waits in that register; the
// arithmetic holds in its finishing step only while that register still
// waits for its transfer. The next frame's last pixel and any pixel that
// starts a new clip are held off with pixel_stall while the arithmetic is
// running.
`include "temporal_information_stddev_max_defines.svh"

module temporal_information_stddev_max #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pixel_valid,
    output logic                                pixel_stall,
    input  tism_pkg::pixel_t                    pixel,
    output logic                                result_valid,
    input  logic                                result_stall,
    output tism_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tism_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tism_pkg::CFG_W-1:0]          cfg_data
);
    import tism_pkg::*;

    localparam int N_W   = tism_n_w(MAX_WIDTH, MAX_HEIGHT);
    localparam int MAG_W = tism_mag_w(MAX_WIDTH, MAX_HEIGHT);
    localparam int Q_W   = tism_q_w(MAX_WIDTH, MAX_HEIGHT);

    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;

    logic             pixel_accept;
    logic             frame_end;
    logic             frame_start;
    logic             result_taken;
    logic             busy;
    logic [N_W-1:0]   pixel_count;
    logic [MAG_W-1:0] sum_mag;
    logic [Q_W-1:0]   square_total;
    tism_cmd_t        cmd;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_next  = cfg_data;
                REG_FRAME_HEIGHT: height_next = cfg_data;
                default:          width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // Pixels that would need the arithmetic unit or disturb the maximum wait.
    assign pixel_stall  = busy && (pixel.first_of_sequence || frame_end);
    assign pixel_accept = pixel_valid && !pixel_stall;
    assign frame_start  = pixel_accept && frame_end;
    assign result_taken = result_valid && !result_stall;

    tism_accum #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT)
    ) u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (pixel_accept),
        .pixel        (pixel),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .frame_end    (frame_end),
        .pixel_count  (pixel_count),
        .sum_mag      (sum_mag),
        .square_total (square_total)
    );

    tism_ctrl #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_start  (frame_start),
        .result_taken (result_taken),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    tism_dp #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .clear_max    (pixel_accept && pixel.first_of_sequence),
        .pixel_count  (pixel_count),
        .sum_mag      (sum_mag),
        .square_total (square_total),
        .result       (result)
    );

    `TISM_ASSERT_IMPL(a_frame_end_idle, clk, rst_n, pixel_accept && frame_end, !busy, "frame end transferred while the arithmetic unit was busy")
    `TISM_ASSERT_IMPL(a_clip_start_idle, clk, rst_n, pixel_accept && pixel.first_of_sequence, !busy, "clip start transferred while the arithmetic unit was busy")
    `TISM_ASSERT_IMPL(a_max_covers_frame, clk, rst_n, result_valid, result.max_ti >= result.frame_ti, "running maximum below the frame value")
    `TISM_ASSERT_NEXT(a_result_retires, clk, rst_n, result_taken && !cmd.finish, !result_valid, "result still offered after its transfer")
    `TISM_ASSERT_NEXT(a_finish_offers, clk, rst_n, cmd.finish, result_valid, "finished result not offered")

endmodule

// ===== tb/temporal_information_stddev_max_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Temporal information block testbench
// Streams temporal-map pixels through the block under random sender gaps and
// receiver stalls, predicts each frame's standard deviation and the running
// clip maximum, and checks every result transfer field by field.
// ----------------------------------------------------------------------------
module temporal_information_stddev_max_test;
    import tism_pkg::*;

    typedef longint unsigned u64_t;

    // How the pixel values of one frame are spread.
    typedef enum int {
        SPREAD_FULL,
        SPREAD_EXTREME,
        SPREAD_NARROW,
        SPREAD_FLAT
    } spread_e;

    localparam int WIDTH_LIMIT    = 2048;
    localparam int HEIGHT_LIMIT   = 2048;
    localparam int DRAIN_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PIXELS  = 510;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 pixel_valid  = 1'b0;
    logic                 pixel_stall;
    pixel_t               pixel        = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    result_t              result;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]     cfg_data     = '0;

    // Predicted block state.
    logic [CFG_W-1:0] model_width       = WIDTH_RESET;
    logic [CFG_W-1:0] model_height      = HEIGHT_RESET;
    longint           frame_sum         = 0;
    u64_t             frame_square_sum  = 0;
    u64_t             frame_pos         = 0;
    logic [15:0]      clip_max          = '0;
    logic             clip_started      = 1'b0;
    result_t          ti_expected[$];

    // Stimulus side.
    pixel_t           pixel_backlog[$];
    logic [CFG_W-1:0] gen_width     = WIDTH_RESET;
    logic [CFG_W-1:0] gen_height    = HEIGHT_RESET;
    u64_t             gen_pos       = 0;
    int unsigned      pixels_queued = 0;
    int unsigned      pixels_taken  = 0;

    int unsigned error_count  = 0;
    int unsigned quiet_cycles = 0;
    int unsigned pixel_wait   = 0;
    int unsigned result_hold  = 0;
    logic        pixel_burst  = 1'b0;
    logic        result_burst = 1'b0;

    temporal_information_stddev_max dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic u64_t pixels_per_frame(input logic [CFG_W-1:0] w,
                                              input logic [CFG_W-1:0] h);
        u64_t ew;
        u64_t eh;
        ew = (w < 2) ? 2 : ((w > WIDTH_LIMIT) ? WIDTH_LIMIT : w);
        eh = (h < 1) ? 1 : ((h > HEIGHT_LIMIT) ? HEIGHT_LIMIT : h);
        return ew * eh;
    endfunction

    function automatic u64_t floor_sqrt(input u64_t x);
        u64_t root;
        u64_t trial;
        root = 0;
        for (int b = 15; b >= 0; b--)
        begin
            trial = root | (u64_t'(1) << b);
            if (trial * trial <= x)
                root = trial;
        end
        return root;
    endfunction

    // Sample standard deviation in 8.8, from n*Q - S*S over n*(n-1).
    function automatic logic [15:0] frame_stddev(input u64_t n, input longint s,
                                                 input u64_t q);
        u64_t mag;
        u64_t num;
        u64_t den;
        u64_t quo;
        u64_t rem;
        u64_t root;
        mag = (s < 0) ? u64_t'(-s) : u64_t'(s);
        num = n * q - mag * mag;
        den = n * (n - 1);
        quo = num / den;
        rem = num % den;
        if (quo >= 65536)
            return 16'hFFFF;
        root = floor_sqrt((quo << 16) + ((rem << 16) / den));
        return root[15:0];
    endfunction

    task automatic absorb_pixel(input pixel_t p);
        longint      v;
        u64_t        n;
        logic [15:0] ti;
        result_t     due;
        n = pixels_per_frame(model_width, model_height);
        if (p.first_of_sequence)
        begin
            clip_max         = '0;
            clip_started     = 1'b0;
            frame_sum        = 0;
            frame_square_sum = 0;
            frame_pos        = 0;
        end
        v = longint'($signed(p.map_value));
        frame_sum        += v;
        frame_square_sum += u64_t'(v * v);
        if (frame_pos + 1 < n)
            frame_pos++;
        else
        begin
            ti = frame_stddev(n, frame_sum, frame_square_sum);
            if (!clip_started || ti > clip_max)
                clip_max = ti;
            clip_started     = 1'b1;
            frame_sum        = 0;
            frame_square_sum = 0;
            frame_pos        = 0;
            due.frame_ti = ti;
            due.max_ti   = clip_max;
            ti_expected.push_back(due);
        end
    endtask

    // Pixel driver and predictor.
    always @(posedge clk)
    begin
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_FRAME_WIDTH)
                model_width = cfg_data;
            else
                model_height = cfg_data;
        end
        if (pixel_valid && !pixel_stall)
        begin
            absorb_pixel(pixel);
            pixels_taken++;
        end
        if (rst_n && (!pixel_valid || !pixel_stall))
        begin
            if (pixel_wait != 0)
            begin
                pixel_wait--;
                pixel_valid <= 1'b0;
            end
            else if (pixel_backlog.size() != 0)
            begin
                pixel       <= pixel_backlog.pop_front();
                pixel_valid <= 1'b1;
                if ($urandom_range(0, 39) == 0)
                    pixel_burst = !pixel_burst;
                pixel_wait = pixel_burst ? 0 : $urandom_range(0, 6);
            end
            else
                pixel_valid <= 1'b0;
        end
    end

    // Result monitor and stall generator.
    always @(posedge clk)
    begin : result_monitor
        result_t due;
        if (rst_n && result_valid && !result_stall)
        begin
            if (ti_expected.size() == 0)
            begin
                $error("unexpected result transfer: frame_ti %0d max_ti %0d",
                       result.frame_ti, result.max_ti);
                error_count++;
            end
            else
            begin
                due = ti_expected.pop_front();
                if (result.frame_ti !== due.frame_ti)
                begin
                    $error("frame_ti mismatch: expected %0d, actual %0d",
                           due.frame_ti, result.frame_ti);
                    error_count++;
                end
                if (result.max_ti !== due.max_ti)
                begin
                    $error("max_ti mismatch: expected %0d, actual %0d",
                           due.max_ti, result.max_ti);
                    error_count++;
                end
            end
            if ($urandom_range(0, 15) == 0)
                result_burst = !result_burst;
            result_hold = result_burst ? 0 : $urandom_range(0, 6);
        end
        if (result_hold != 0)
        begin
            result_hold--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // Ends the run if no transfer of any kind happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (pixel_valid && !pixel_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("temporal_information_stddev_max verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
            gen_width = value;
        else
            gen_height = value;
        @(posedge clk);
    endtask

    // The generator mirrors the frame position so that phases end on frame
    // boundaries unless a test wants otherwise.
    task automatic push_pixel(input logic signed [8:0] value, input logic fos);
        pixel_t p;
        p.map_value         = value;
        p.first_of_sequence = fos;
        pixel_backlog.push_back(p);
        pixels_queued++;
        if (fos)
            gen_pos = 0;
        gen_pos++;
        if (gen_pos >= pixels_per_frame(gen_width, gen_height))
            gen_pos = 0;
    endtask

    task automatic settle();
        while (pixels_taken != pixels_queued || ti_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [8:0] draw_value(input spread_e spread,
                                                     input logic signed [8:0] base);
        logic [8:0] raw;
        case (spread)
            SPREAD_FULL:
                raw = 9'($urandom_range(0, 511));
            SPREAD_EXTREME:
                case ($urandom_range(0, 3))
                    0: raw = 9'h100;
                    1: raw = 9'h101;
                    2: raw = 9'h0FF;
                    default: raw = 9'h000;
                endcase
            SPREAD_NARROW:
                raw = base ^ 9'($urandom_range(0, 3));
            default:
                raw = base;
        endcase
        return $signed(raw);
    endfunction

    task automatic queue_frame(input spread_e spread, input logic fos_first);
        logic signed [8:0] base;
        base = draw_value(SPREAD_FULL, 9'sd0);
        push_pixel(draw_value(spread, base), fos_first);
        while (gen_pos != 0)
        begin
            // Now and then a clip restarts in the middle of a frame.
            push_pixel(draw_value(spread, base), $urandom_range(0, 199) == 0);
        end
    endtask

    initial
    begin : stimulus
        int unsigned random_start;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A partial frame at the reset size, then the frame shrinks under it.
        push_pixel(9'sd100, 1'b1);
        push_pixel(-9'sd100, 1'b0);
        push_pixel(9'sd0, 1'b0);
        settle();
        write_reg(REG_FRAME_WIDTH, 12'd0);
        write_reg(REG_FRAME_HEIGHT, 12'd0);
        push_pixel(9'sd0, 1'b0);

        // Two-pixel frames: saturated deviation, zero deviation, new clip.
        push_pixel(-9'sd256, 1'b0);
        push_pixel(9'sd255, 1'b0);
        push_pixel(9'sd255, 1'b0);
        push_pixel(9'sd255, 1'b0);
        push_pixel(-9'sd255, 1'b1);
        push_pixel(9'sd0, 1'b0);
        settle();

        // Four-pixel frames, a clip restart mid frame, then growth mid frame.
        write_reg(REG_FRAME_WIDTH, 12'd1);
        write_reg(REG_FRAME_HEIGHT, 12'd2);
        queue_frame(SPREAD_EXTREME, 1'b0);
        push_pixel(9'sd17, 1'b0);
        push_pixel(-9'sd40, 1'b0);
        push_pixel(9'sd3, 1'b1);
        push_pixel(-9'sd1, 1'b0);
        push_pixel(9'sd120, 1'b0);
        push_pixel(-9'sd90, 1'b0);
        push_pixel(9'sd60, 1'b0);
        push_pixel(9'sd61, 1'b0);
        settle();
        write_reg(REG_FRAME_HEIGHT, 12'd3);
        repeat (4) push_pixel(draw_value(SPREAD_FULL, 9'sd0), 1'b0);
        settle();

        // Largest height, cut short by a shrink with a zero-sum partial frame.
        write_reg(REG_FRAME_WIDTH, 12'd0);
        write_reg(REG_FRAME_HEIGHT, 12'd4095);
        push_pixel(9'sd7, 1'b1);
        push_pixel(-9'sd7, 1'b0);
        push_pixel(9'sd200, 1'b0);
        push_pixel(-9'sd200, 1'b0);
        push_pixel(9'sd0, 1'b0);
        settle();
        write_reg(REG_FRAME_HEIGHT, 12'd0);
        push_pixel(9'sd0, 1'b0);
        settle();

        // Largest width, cut short by a shrink once a few pixels are in.
        write_reg(REG_FRAME_WIDTH, 12'd4095);
        push_pixel(9'sd50, 1'b0);
        push_pixel(-9'sd30, 1'b0);
        push_pixel(9'sd255, 1'b0);
        push_pixel(-9'sd255, 1'b0);
        settle();
        write_reg(REG_FRAME_WIDTH, 12'd2);
        push_pixel(9'sd10, 1'b0);
        settle();

        random_start = pixels_queued;
        while (pixels_queued - random_start < RANDOM_PIXELS)
        begin
            settle();
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_FRAME_WIDTH, ($urandom_range(0, 7) == 0) ?
                          12'($urandom_range(9, 32)) : 12'($urandom_range(0, 8)));
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_FRAME_HEIGHT, ($urandom_range(0, 7) == 0) ?
                          12'($urandom_range(5, 6)) : 12'($urandom_range(0, 4)));
            repeat ($urandom_range(1, 5))
                queue_frame(spread_e'($urandom_range(0, 3)), $urandom_range(0, 5) == 0);
        end

        settle();
        if (error_count == 0)
            $display("temporal_information_stddev_max verification clean");
        else
            $display("temporal_information_stddev_max verification failed");
        $finish;
    end

endmodule
